// ===== hw/rtl/keypad_scan_debounce_unit_defines.svh =====
// assertion helpers for the keypad scanner
`ifndef KEYPAD_SCAN_DEBOUNCE_UNIT_DEFINES_SVH
`define KEYPAD_SCAN_DEBOUNCE_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define KSD_ASSERT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define KSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/kpd_pkg.sv =====
`timescale 1ns / 1ps

package kpd_pkg;

  // default matrix size
  localparam int Rows    = 4;
  localparam int Columns = 4;

  // fixed field widths
  localparam int LevelWidth = 4;
  localparam int MaskWidth  = 4;
  localparam int ColWidth   = 2;
  localparam int CountWidth = 8;

  // settle time after reset
  localparam logic [CountWidth-1:0] SettleReset = 8'd1;

  // per-row lane findings
  typedef struct packed {
    logic press;
    logic pressed;
  } lane_res_t;

  // one result beat, scanned_column in the lowest bits
  typedef struct packed {
    logic [ColWidth-1:0]  drive_column;
    logic [MaskWidth-1:0] key_state;
    logic [MaskWidth-1:0] press_mask;
    logic [ColWidth-1:0]  scanned_column;
  } beat_t;

endpackage

// ===== hw/rtl/kpd_lane.sv =====
`timescale 1ns / 1ps

// debounce state of one matrix row, one entry per column
module kpd_lane #(
  parameter int COLUMNS = kpd_pkg::Columns
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  logic [$clog2(COLUMNS)-1:0]          col,
  input  logic                                sample_high,
  input  logic [kpd_pkg::CountWidth-1:0]      settle,
  output kpd_pkg::lane_res_t                  res
);

  localparam int CntW = kpd_pkg::CountWidth;

  logic            pressed [COLUMNS];
  logic [CntW-1:0] holdoff [COLUMNS];

  logic            pressed_next;
  logic [CntW-1:0] holdoff_next;
  logic            now;
  logic            change;

  // sample when the hold-off has run out, otherwise count down
  always_comb begin
    now          = ~sample_high;
    change       = 1'b0;
    pressed_next = pressed[col];
    holdoff_next = holdoff[col];
    if (holdoff[col] == '0) begin
      change       = now != pressed[col];
      pressed_next = now;
      holdoff_next = change ? settle : '0;
    end else begin
      holdoff_next = holdoff[col] - CntW'(1);
    end
    res.press   = change & now;
    res.pressed = pressed_next;
  end

  // write back the entry of the scanned column
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < COLUMNS; c++) begin
        pressed[c] <= 1'b0;
        holdoff[c] <= '0;
      end
    end else if (advance) begin
      pressed[col] <= pressed_next;
      holdoff[col] <= holdoff_next;
    end
  end

endmodule

// ===== hw/rtl/kpd_merge.sv =====
`timescale 1ns / 1ps

`include "keypad_scan_debounce_unit_defines.svh"

// gathers the lane findings into a beat and buffers it two deep
module kpd_merge #(
  parameter int ROWS = kpd_pkg::Rows
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [kpd_pkg::ColWidth-1:0]       scanned_column,
  input  logic [kpd_pkg::ColWidth-1:0]       drive_column,
  input  kpd_pkg::lane_res_t                 lane_res [ROWS],
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output kpd_pkg::beat_t                     m_beat
);

  localparam int MaskW = kpd_pkg::MaskWidth;

  kpd_pkg::beat_t    beat_new;
  kpd_pkg::beat_t    skid;
  logic              skid_valid;
  logic [MaskW-1:0]  mask;
  logic [MaskW-1:0]  state;
  logic              accept;

  // rows beyond the matrix read as zero
  for (genvar r = 0; r < MaskW; r++) begin : g_pack
    if (r < ROWS) begin : g_row
      assign mask[r]  = lane_res[r].press;
      assign state[r] = lane_res[r].pressed;
    end else begin : g_none
      assign mask[r]  = 1'b0;
      assign state[r] = 1'b0;
    end
  end

  always_comb begin
    beat_new.scanned_column = scanned_column;
    beat_new.press_mask     = mask;
    beat_new.key_state      = state;
    beat_new.drive_column   = drive_column;
  end

  assign in_ready = ~skid_valid;
  assign accept   = in_valid & in_ready;

  // output register with skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        m_beat     <= skid;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!m_tvalid || m_tready) begin
        m_beat   <= beat_new;
        m_tvalid <= 1'b1;
      end else begin
        skid       <= beat_new;
        skid_valid <= 1'b1;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  `KSD_ASSERT(a_skid_behind_out, clk, rst, skid_valid, m_tvalid, "skid full with output empty")
  `KSD_ASSERT_NEXT(a_stall_to_skid, clk, rst, accept && m_tvalid && !m_tready, skid_valid, "stalled beat not parked")
  `KSD_ASSERT_NEXT(a_skid_drain, clk, rst, skid_valid && m_tready, !skid_valid && m_tvalid, "skid beat not moved out")

endmodule

// ===== hw/rtl/keypad_scan_debounce_unit.sv =====
`timescale 1ns / 1ps

// Key matrix scanner with per-key debounce.
// s_tdata carries the row pin levels of the column currently driven (low
// means pressed); each accepted beat is one scan tick. Every row has its own
// lane holding the debounced state and hold-off counter of each column, so
// all rows of a column are updated in the same cycle.
// m_tdata returns the scanned column, its new press edges, its debounced
// states and the column to drive for the next tick.
// cfg_data sets the settle time in scan ticks; it is always ready and should
// be written while no beat is in flight.
// Each result is registered: it goes to the output register, or to the skid entry
// while the receiver stalls. Throughput: one beat per cycle while s_tready is high.
// Results go through an output register backed by one skid entry: a stalled
// receiver lets one more beat in, then s_tready drops until the skid drains.
// Reset clears all key states and counters, scans column 0 first and loads a
// settle time of one tick.
module keypad_scan_debounce_unit #(
  parameter int ROWS    = kpd_pkg::Rows,
  parameter int COLUMNS = kpd_pkg::Columns
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] row_levels
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [1:0] scanned_column, [5:2] press_mask,
                                 // [9:6] key_state, [11:10] drive_column
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data   // settle_ticks
);

  localparam int IdxW  = $clog2(COLUMNS);
  localparam int ColW  = kpd_pkg::ColWidth;
  localparam int CntW  = kpd_pkg::CountWidth;
  localparam int LvlW  = kpd_pkg::LevelWidth;

  logic [IdxW-1:0]     column_index;
  logic [IdxW-1:0]     column_index_next;
  logic [CntW-1:0]     settle_ticks;
  logic                accept;
  kpd_pkg::lane_res_t  lane_res [ROWS];
  kpd_pkg::beat_t      m_beat;

  assign accept    = s_tvalid & s_tready;
  assign cfg_ready = 1'b1;

  // settle register
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ticks <= kpd_pkg::SettleReset;
    end else if (cfg_valid) begin
      settle_ticks <= cfg_data;
    end
  end

  // column scan counter
  assign column_index_next = (column_index == IdxW'(COLUMNS - 1)) ? '0
                                                                 : column_index + IdxW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
    end else if (accept) begin
      column_index <= column_index_next;
    end
  end

  // one lane per row; rows without a pin read as released
  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    logic row_high;
    if (r < LvlW) begin : g_pin
      assign row_high = s_tdata[r];
    end else begin : g_nopin
      assign row_high = 1'b1;
    end

    kpd_lane #(
      .COLUMNS (COLUMNS)
    ) u_lane (
      .clk         (clk),
      .rst         (rst),
      .advance     (accept),
      .col         (column_index),
      .sample_high (row_high),
      .settle      (settle_ticks),
      .res         (lane_res[r])
    );
  end

  kpd_merge #(
    .ROWS (ROWS)
  ) u_merge (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_tvalid),
    .in_ready       (s_tready),
    .scanned_column (ColW'(column_index)),
    .drive_column   (ColW'(column_index_next)),
    .lane_res       (lane_res),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_beat         (m_beat)
  );

  assign m_tdata = {4'b0000, m_beat};

endmodule

// ===== verif/keypad_scan_checker.sv =====
`timescale 1ns / 1ps

module keypad_scan_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [3:0] row_levels
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [1:0] scanned_column, [5:2] press_mask,
                                 // [9:6] key_state, [11:10] drive_column
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,  // settle_ticks
  output int          errors,
  output int          pending
);

  localparam int Rows       = kpd_pkg::Rows;
  localparam int Columns    = kpd_pkg::Columns;
  localparam int CountWidth = kpd_pkg::CountWidth;
  localparam int ColWidth   = kpd_pkg::ColWidth;
  localparam int LevelWidth = kpd_pkg::LevelWidth;
  localparam int Keys       = Rows * Columns;

  // shadow copy of the scanner state
  logic [CountWidth-1:0] settle;
  logic [ColWidth-1:0]   scan_col;
  logic [Keys-1:0]       debounced;
  logic [CountWidth-1:0] holdoff [Keys];
  kpd_pkg::beat_t        scan_expected [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("checker: %0t %s mismatch, got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  // one scan tick: update the keys of the driven column, queue the result beat
  task automatic predict_scan(input logic [LevelWidth-1:0] levels);
    kpd_pkg::beat_t res;
    int    r;
    int    k;
    logic  now_pressed;
    res = '0;
    res.scanned_column = scan_col;
    for (r = 0; r < Rows; r++) begin
      k = r * Columns + scan_col;
      if (holdoff[k] == '0) begin
        // low level means pressed
        now_pressed = ~levels[r];
        if (now_pressed != debounced[k]) begin
          debounced[k] = now_pressed;
          holdoff[k]   = settle;
          if (now_pressed) res.press_mask[r] = 1'b1;
        end
      end else begin
        holdoff[k] = holdoff[k] - 1'b1;
      end
      res.key_state[r] = debounced[k];
    end
    scan_col = (scan_col >= Columns - 1) ? '0 : scan_col + 1'b1;
    res.drive_column = scan_col;
    scan_expected.push_back(res);
  endtask

  // compare a result beat with the oldest prediction
  task automatic check_result(input logic [15:0] data);
    kpd_pkg::beat_t got;
    kpd_pkg::beat_t want;
    got = data[$bits(kpd_pkg::beat_t)-1:0];
    if (scan_expected.size() == 0) begin
      report_mismatch("unexpected result beat", data, 0);
      return;
    end
    want = scan_expected.pop_front();
    if (got.scanned_column != want.scanned_column)
      report_mismatch("scanned_column", got.scanned_column, want.scanned_column);
    if (got.press_mask != want.press_mask)
      report_mismatch("press_mask", got.press_mask, want.press_mask);
    if (got.key_state != want.key_state)
      report_mismatch("key_state", got.key_state, want.key_state);
    if (got.drive_column != want.drive_column)
      report_mismatch("drive_column", got.drive_column, want.drive_column);
    if (data[15:$bits(kpd_pkg::beat_t)] != '0)
      report_mismatch("tdata padding", data[15:$bits(kpd_pkg::beat_t)], 0);
  endtask

  // watch all three channels
  always @(posedge clk) begin
    int k;
    if (rst) begin
      settle    = kpd_pkg::SettleReset;
      scan_col  = '0;
      debounced = '0;
      for (k = 0; k < Keys; k++) holdoff[k] = '0;
      scan_expected.delete();
    end else begin
      if (m_tvalid && m_tready) check_result(m_tdata);
      if (cfg_valid && cfg_ready) settle = cfg_data;
      if (s_tvalid && s_tready) predict_scan(s_tdata[LevelWidth-1:0]);
    end
    pending <= scan_expected.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int Rows       = kpd_pkg::Rows;
  localparam int Columns    = kpd_pkg::Columns;
  localparam int LevelWidth = kpd_pkg::LevelWidth;
  localparam int ColWidth   = kpd_pkg::ColWidth;

  localparam int IdleLimit = 1000;
  localparam int LongStall = 80;
  localparam int PhaseBeats = 320;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic [7:0]  s_tdata   = '0;
  logic        m_tready  = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [7:0]  cfg_data  = '0;
  wire         s_tready;
  wire         m_tvalid;
  wire  [15:0] m_tdata;
  wire         cfg_ready;

  int errors;
  int pending;
  int beats_sent  = 0;
  int idle_cycles = 0;
  bit stall_done  = 1'b0;

  // column the scanner drives next, and the keys physically held down
  logic [ColWidth-1:0]     drive_col = '0;
  logic [Rows*Columns-1:0] held_keys = '0;

  keypad_scan_debounce_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  keypad_scan_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 6);
  endfunction

  // row levels of the driven column, with occasional contact bounce
  function automatic logic [LevelWidth-1:0] column_levels();
    logic [LevelWidth-1:0] lv;
    int r;
    for (r = 0; r < Rows; r++) lv[r] = ~held_keys[r * Columns + drive_col];
    if ($urandom_range(7) == 0) lv[$urandom_range(Rows - 1)] ^= 1'b1;
    return lv;
  endfunction

  task automatic send_scan(input logic [LevelWidth-1:0] levels, input int gap);
    s_tvalid <= 1'b1;
    s_tdata  <= {{(8 - LevelWidth){1'b0}}, levels};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_sent++;
    drive_col = (drive_col >= Columns - 1) ? '0 : drive_col + 1'b1;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering and wait until every result beat is back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_settle(input logic [7:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // key presses and releases with bounce, mixed with raw noise
  task automatic run_phase(input logic [7:0] value, input int count);
    logic [LevelWidth-1:0] lv;
    int gap;
    int i;
    write_settle(value);
    for (i = 0; i < count; i++) begin
      if ($urandom_range(19) == 0) held_keys[$urandom_range(Rows * Columns - 1)] ^= 1'b1;
      if ($urandom_range(99) < 15) lv = LevelWidth'($urandom_range(15));
      else lv = column_levels();
      gap = ((i / 64) % 3 == 1) ? 0 : pick_gap();
      send_scan(lv, gap);
    end
  endtask

  // receiver: ready runs and gaps, one long hold-off so the skid fills
  initial begin : receiver
    int stall;
    @(negedge rst);
    forever begin
      if (!stall_done && beats_sent >= 400) begin
        stall_done = 1'b1;
        m_tready <= 1'b0;
        for (stall = 0; stall < LongStall; stall++) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat (($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(20, 1))
        @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [LevelWidth-1:0] opening [24];
    int i;
    opening = '{4'hF, 4'hF, 4'hF, 4'hF, 4'h0, 4'h0, 4'h0, 4'h0,
                4'h0, 4'h0, 4'h0, 4'h0, 4'hF, 4'hF, 4'hF, 4'hF,
                4'hF, 4'hF, 4'hF, 4'hF, 4'h5, 4'hA, 4'h5, 4'hA};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: all released, all pressed and held, release, checkerboards
    for (i = 0; i < 24; i++) send_scan(opening[i], pick_gap());

    // zero settle, longest settle, a random one, back to one tick
    run_phase(8'd0, PhaseBeats);
    run_phase(8'd255, PhaseBeats);
    run_phase(8'($urandom_range(30, 2)), PhaseBeats);
    run_phase(8'd1, PhaseBeats);

    drain();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
